@@ hdl/gss_pkg.sv @@
package gss_pkg;

    localparam int unsigned COORD_W = 32;
    localparam int unsigned IDX_W   = 6;
    localparam int unsigned RATIO_W = 32;
    localparam int unsigned WORD_W  = 64;
    localparam int unsigned PROD_W  = 128;
    localparam int unsigned HALF_W  = 32;
    localparam int unsigned DEPTH   = 64;

    localparam logic [WORD_W-1:0] POW_SAT  = (64'd1 << 62) - 64'd1;
    localparam logic [WORD_W-1:0] STEP_SAT = 64'd1 << 40;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PMUL,
        ST_PWAIT,
        ST_QMUL,
        ST_QWAIT,
        ST_DWAIT,
        ST_OUT,
        ST_RD,
        ST_SMUL,
        ST_SWAIT
    } t_state;

endpackage

@@ hdl/gss_mul.sv @@
module gss_mul
    import gss_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [WORD_W-1:0]   i_a,
    input  logic [WORD_W-1:0]   i_b,
    output logic                o_done,
    output logic [PROD_W-1:0]   o_prod
);

    logic [2:0]           r_cnt;
    logic                 r_busy;
    logic [WORD_W-1:0]    r_a;
    logic [WORD_W-1:0]    r_b;
    logic [WORD_W-1:0]    r_pp;
    logic [1:0]           r_sh;
    logic                 r_pv;
    logic [PROD_W-1:0]    r_acc;
    logic [HALF_W-1:0]    w_am;
    logic [HALF_W-1:0]    w_bm;

    assign w_am   = r_cnt[0] ? r_a[WORD_W-1:HALF_W] : r_a[HALF_W-1:0];
    assign w_bm   = r_cnt[1] ? r_b[WORD_W-1:HALF_W] : r_b[HALF_W-1:0];
    assign o_prod = r_acc;
    assign o_done = r_busy && (r_cnt == 3'd5);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_pv   <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_pv   <= 1'b0;
        end else if (r_busy) begin
            r_pv <= (r_cnt < 3'd4);
            if (r_cnt == 3'd5) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 3'd1;
            end
        end else begin
            r_pv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else begin
            r_pp <= w_am * w_bm;
            r_sh <= {1'b0, r_cnt[0]} + {1'b0, r_cnt[1]};
            if (r_pv) begin
                r_acc <= r_acc + ({{WORD_W{1'b0}}, r_pp} << (HALF_W * r_sh));
            end
        end
    end

endmodule

@@ hdl/gss_div.sv @@
module gss_div
    import gss_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [WORD_W-1:0]   i_num,
    input  logic [WORD_W-1:0]   i_den,
    output logic                o_done,
    output logic [WORD_W-1:0]   o_quo
);

    logic [6:0]          r_cnt;
    logic                r_busy;
    logic [WORD_W-1:0]   r_rem;
    logic [WORD_W-1:0]   r_q;
    logic [WORD_W-1:0]   r_den;
    logic [WORD_W:0]     w_sh;
    logic [WORD_W:0]     w_diff;
    logic                w_ge;

    assign w_sh   = {r_rem, r_q[WORD_W-1]};
    assign w_diff = w_sh - {1'b0, r_den};
    assign w_ge   = (w_sh >= {1'b0, r_den});
    assign o_done = r_busy && (r_cnt == 7'(WORD_W));
    assign o_quo  = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (r_cnt == 7'(WORD_W)) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 7'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_num;
            r_den <= i_den;
        end else if (r_busy && (r_cnt != 7'(WORD_W))) begin
            r_rem <= w_ge ? w_diff[WORD_W-1:0] : w_sh[WORD_W-1:0];
            r_q   <= {r_q[WORD_W-2:0], w_ge};
        end
    end

endmodule

@@ hdl/geometric_segment_splitter_unit.sv @@
// First node: a pass of the shared 64x64 multiply (four 32x32 steps) per power and one
// for h, then the restoring divider; q of one skips the h pass, and a final power of
// one (q not one) skips both.
// Input ready only when idle; each middle node takes one pass of the shared multiply.
// Reset: synchronous, active low; clears the sequencer and handshakes.
module geometric_segment_splitter_unit
    import gss_pkg::*;
#(
    parameter int unsigned MAX_DIVISIONS   = 63,
    parameter int unsigned RATIO_FRAC_BITS = 30
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // seg_start[31:0], seg_end[63:32], divisions[69:64], ratio[101:70],
    // dense_at_start[102], zero pad
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // point[31:0], point_index[37:32], zero pad
    output logic [39:0]  m_axis_tdata,
    output logic         m_axis_tlast
);

    localparam logic [WORD_W-1:0] ONE = WORD_W'(1) << RATIO_FRAC_BITS;
    localparam logic [IDX_W-1:0]  NMAX = IDX_W'(MAX_DIVISIONS);

    t_state r_state, n_state;

    logic signed [COORD_W-1:0] r_s, r_e, r_rp;
    logic [IDX_W-1:0]          r_n, r_k, r_idx, r_raddr;
    logic [RATIO_W-1:0]        r_q;
    logic                      r_dense, r_neg;
    logic [WORD_W-1:0]         r_p, r_hm, r_rd, r_dm;
    logic [WORD_W-1:0]         mem [DEPTH];

    logic                      mul_start, mul_done, div_start, div_done;
    logic [WORD_W-1:0]         mul_a, mul_b, div_num, div_den, div_quo;
    logic [PROD_W-1:0]         mul_prod;

    logic [IDX_W-1:0]          w_nin, w_ncl, w_inext, w_kaddr;
    logic [WORD_W-1:0]         w_pk, w_pr, w_qm, w_pm, w_sp, w_st;
    logic signed [COORD_W:0]   w_d;
    logic signed [42:0]        w_sum;
    logic signed [COORD_W-1:0] w_sat;
    logic                      w_wr;
    logic [IDX_W-1:0]          w_waddr;
    logic [WORD_W-1:0]         w_wdata;

    gss_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(mul_start),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_done (mul_done),
        .o_prod (mul_prod)
    );

    gss_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (div_den),
        .o_done (div_done),
        .o_quo  (div_quo)
    );

    assign w_nin = s_axis_tdata[69:64];
    assign w_ncl = (w_nin == '0) ? IDX_W'(1) : ((w_nin > NMAX) ? NMAX : w_nin);
    assign w_d   = {s_axis_tdata[63], s_axis_tdata[63:32]} -
                   {s_axis_tdata[31], s_axis_tdata[31:0]};

    assign w_pr = mul_prod[WORD_W-1:0] >> RATIO_FRAC_BITS;
    assign w_pk = (|mul_prod[PROD_W-1:WORD_W]) ? POW_SAT :
                  ((w_pr > POW_SAT) ? POW_SAT : w_pr);
    assign w_sp = ((|mul_prod[PROD_W-1:WORD_W]) ? {WORD_W{1'b1}} : mul_prod[WORD_W-1:0])
                  >> RATIO_FRAC_BITS;
    assign w_st = (w_sp > STEP_SAT) ? STEP_SAT : w_sp;
    assign w_qm = ({32'd0, r_q} > ONE) ? ({32'd0, r_q} - ONE) : (ONE - {32'd0, r_q});
    assign w_pm = (r_p > ONE) ? (r_p - ONE) : (ONE - r_p);

    assign w_sum = r_neg ? (43'(r_rp) - $signed({2'b00, w_st[40:0]}))
                         : (43'(r_rp) + $signed({2'b00, w_st[40:0]}));
    assign w_sat = (w_sum > 43'sd2147483647)  ? 32'sh7fffffff :
                   (w_sum < -43'sd2147483648) ? 32'sh80000000 : w_sum[COORD_W-1:0];

    assign w_inext = r_idx + IDX_W'(1);
    assign w_kaddr = r_dense ? r_idx : (r_n - w_inext);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = {2'b00, r_idx, r_rp};
    assign m_axis_tlast  = (r_idx == r_n);

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rd <= mem[r_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        mul_start = 1'b0;
        mul_a     = r_p;
        mul_b     = {32'd0, r_q};
        div_start = 1'b0;
        div_num   = mul_prod[WORD_W-1:0];
        div_den   = w_pm;
        w_wr      = 1'b0;
        w_waddr   = r_k;
        w_wdata   = w_pk;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    w_wr    = 1'b1;
                    w_waddr = '0;
                    w_wdata = ONE;
                    n_state = ST_PMUL;
                end
            end
            ST_PMUL: begin
                mul_start = 1'b1;
                n_state   = ST_PWAIT;
            end
            ST_PWAIT: begin
                if (mul_done) begin
                    w_wr    = 1'b1;
                    n_state = (r_k == r_n) ? ST_QMUL : ST_PMUL;
                end
            end
            ST_QMUL: begin
                if ({32'd0, r_q} == ONE) begin
                    div_start = 1'b1;
                    div_num   = r_dm;
                    div_den   = {{(WORD_W-IDX_W){1'b0}}, r_n};
                    n_state   = ST_DWAIT;
                end else if (w_pm == '0) begin
                    n_state = ST_OUT;
                end else begin
                    mul_start = 1'b1;
                    mul_a     = r_dm;
                    mul_b     = w_qm;
                    n_state   = ST_QWAIT;
                end
            end
            ST_QWAIT: begin
                if (mul_done) begin
                    div_start = 1'b1;
                    n_state   = ST_DWAIT;
                end
            end
            ST_DWAIT: begin
                if (div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_axis_tready) begin
                    if (r_idx == r_n) begin
                        n_state = ST_IDLE;
                    end else if (w_inext == r_n) begin
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_RD;
                    end
                end
            end
            ST_RD: begin
                n_state = ST_SMUL;
            end
            ST_SMUL: begin
                mul_start = 1'b1;
                mul_a     = r_hm;
                mul_b     = r_rd;
                n_state   = ST_SWAIT;
            end
            ST_SWAIT: begin
                if (mul_done) begin
                    n_state = ST_OUT;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    r_s     <= s_axis_tdata[31:0];
                    r_e     <= s_axis_tdata[63:32];
                    r_n     <= w_ncl;
                    r_q     <= s_axis_tdata[101:70];
                    r_dense <= s_axis_tdata[102];
                    r_neg   <= w_d[COORD_W];
                    r_dm    <= {{(WORD_W-COORD_W-1){1'b0}},
                                (w_d[COORD_W] ? -w_d : w_d)};
                    r_p     <= ONE;
                    r_k     <= IDX_W'(1);
                end
            end
            ST_PWAIT: begin
                if (mul_done) begin
                    r_p <= w_pk;
                    r_k <= r_k + IDX_W'(1);
                end
            end
            ST_QMUL: begin
                if (({32'd0, r_q} != ONE) && (w_pm == '0)) begin
                    r_hm  <= r_dm;
                    r_rp  <= r_s;
                    r_idx <= '0;
                end
            end
            ST_DWAIT: begin
                if (div_done) begin
                    r_hm  <= div_quo;
                    r_rp  <= r_s;
                    r_idx <= '0;
                end
            end
            ST_OUT: begin
                if (m_axis_tready && (r_idx != r_n)) begin
                    r_idx   <= w_inext;
                    r_raddr <= w_kaddr;
                    if (w_inext == r_n) begin
                        r_rp <= r_e;
                    end
                end
            end
            ST_SWAIT: begin
                if (mul_done) begin
                    r_rp <= w_sat;
                end
            end
            default: begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while a node is pending");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("block not ready after final node");

    a_last_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast && (r_n != '0)) |-> (r_rp == r_e || r_idx == '0))
        else $error("final node differs from segment end");
`endif

endmodule
